// ===== hw/rtl/lob_pkg.sv =====
// shared types and constants for the level overlap boundary detector
// used by lob_match, lob_hist and level_overlap_boundary_detector; no dependencies
package lob_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int HALF_LEVELS = MAX_LEVELS / 2;
    localparam int LEVEL_W = 16;
    localparam int CNT_W = 4;
    localparam int SUM_W = CNT_W + 1;
    localparam int HIST_SIDE = 9;
    localparam int HIST_BINS = HIST_SIDE * HIST_SIDE;
    localparam int BIN_W = 7;
    localparam int COUNT_W = 32;
    localparam int ROW_W = 48;
    localparam int THR_W = 5;
    localparam int KIND_W = 2;
    localparam int HALF_W = HALF_LEVELS * LEVEL_W;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);

    // input word layout
    localparam int S_TDATA_W = 264;
    localparam int ASK_LO_OFS = 0;
    localparam int ASK_HI_OFS = ASK_LO_OFS + HALF_W;
    localparam int BID_LO_OFS = ASK_HI_OFS + HALF_W;
    localparam int BID_HI_OFS = BID_LO_OFS + HALF_W;
    localparam int BIN_IDX_OFS = BID_HI_OFS + HALF_W;
    localparam int S_PAD_W = S_TDATA_W - BIN_IDX_OFS - BIN_W;

    // output word layout
    localparam int M_TDATA_W = 96;
    localparam int M_PAD_W = M_TDATA_W - ROW_W - 2 - 2 * CNT_W - COUNT_W;

    typedef enum logic [KIND_W-1:0] {
        OP_ROW    = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef struct packed {
        logic             rd;
        logic             bump;
        logic [BIN_W-1:0] addr;
    } hist_req_t;

endpackage

// ===== hw/rtl/lob_match.sv =====
// overlap counter: how many previous levels appear among the current levels
// depends on lob_pkg
module lob_match #(
    parameter int LEVELS = lob_pkg::MAX_LEVELS
) (
    input  logic [lob_pkg::LEVEL_W-1:0] prev_lvl [LEVELS],
    input  logic [lob_pkg::LEVEL_W-1:0] cur_lvl  [LEVELS],
    output logic [lob_pkg::CNT_W-1:0]   count
);

    logic [LEVELS-1:0] hit;

    always_comb begin
        for (int j = 0; j < LEVELS; j++) begin
            hit[j] = 1'b0;
            for (int k = 0; k < LEVELS; k++) begin
                if (prev_lvl[j] == cur_lvl[k]) begin
                    hit[j] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        count = '0;
        for (int j = 0; j < LEVELS; j++) begin
            count = count + lob_pkg::CNT_W'(hit[j]);
        end
    end

endmodule

// ===== hw/rtl/lob_hist.sv =====
// overlap histogram: 81-bin memory with per-bin valid bits, saturating
// read-modify-write and write-to-read forwarding; depends on lob_pkg
module lob_hist (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  lob_pkg::hist_req_t          req,
    output logic [lob_pkg::COUNT_W-1:0] count
);

    logic [lob_pkg::COUNT_W-1:0] hist_mem [lob_pkg::HIST_BINS];
    logic [lob_pkg::HIST_BINS-1:0] vld_reg;

    logic [lob_pkg::COUNT_W-1:0] q_reg;
    logic                        q_vld_reg;
    logic                        fwd_reg;
    logic [lob_pkg::COUNT_W-1:0] fwd_data_reg;
    logic                        bump_reg;
    logic [lob_pkg::BIN_W-1:0]   addr_reg;

    logic [lob_pkg::COUNT_W-1:0] bumped;
    logic                        wr_en;

    always_comb begin
        if (fwd_reg) begin
            count = fwd_data_reg;
        end else if (q_vld_reg) begin
            count = q_reg;
        end else begin
            count = '0;
        end
        bumped = (count == '1) ? count : count + lob_pkg::COUNT_W'(1);
    end

    assign wr_en = en && bump_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[addr_reg] <= bumped;
        end
        if (req.rd) begin
            q_reg <= hist_mem[req.addr];
            fwd_data_reg <= bumped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            q_vld_reg <= 1'b0;
            fwd_reg <= 1'b0;
            bump_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (req.rd) begin
                q_vld_reg <= vld_reg[req.addr];
                fwd_reg <= wr_en && (addr_reg == req.addr);
            end
            if (en) begin
                bump_reg <= req.bump;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg <= req.addr;
        end
    end

`ifndef ASSERT_OFF
    a_bump_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        req.bump |-> req.rd)
        else $error("histogram bump issued without a read");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        req.rd |-> req.addr < lob_pkg::BIN_W'(lob_pkg::HIST_BINS))
        else $error("histogram read beyond last bin");

    a_written_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> vld_reg[$past(addr_reg)])
        else $error("written bin not marked valid");
`endif

endmodule

// ===== hw/rtl/level_overlap_boundary_detector.sv =====
// top level of the level overlap boundary detector
// depends on lob_pkg, lob_match and lob_hist
//
// One word is taken per clock unless back-pressured, and each word of op row, finish or read
// gives one result word via the stage 1 and output registers. Row words are compared against
// the previous row's levels combinationally by two banks of equality comparators; the
// histogram bin is read from a registered-read memory and written back incremented, with
// forwarding so rows hitting the same bin back to back count correctly. Op 3 words are taken
// and dropped. The histogram starts at zero out of reset with no clearing pass. The threshold
// may be written at any time the block is idle and takes effect for the next row.
module level_overlap_boundary_detector #(
    parameter int LEVELS = lob_pkg::MAX_LEVELS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // threshold write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lob_pkg::THR_W-1:0]     cfg_data,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ask_levels_low, ask_levels_high, bid_levels_low, bid_levels_high, bin_index
    input  logic [lob_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [lob_pkg::KIND_W-1:0]    s_tuser,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // row_index, is_boundary, pair_valid, ask_overlap, bid_overlap, bin_count
    output logic [lob_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [lob_pkg::KIND_W-1:0]    m_tuser
);

    logic [lob_pkg::THR_W-1:0] thr_reg;

    logic [lob_pkg::LEVEL_W-1:0] prev_ask_reg [LEVELS];
    logic [lob_pkg::LEVEL_W-1:0] prev_bid_reg [LEVELS];
    logic [lob_pkg::LEVEL_W-1:0] cur_ask [LEVELS];
    logic [lob_pkg::LEVEL_W-1:0] cur_bid [LEVELS];
    logic                        have_prev_reg;
    logic [lob_pkg::ROW_W-1:0]   row_cnt_reg;

    logic                        en;
    logic                        accept;
    logic                        is_row;
    logic                        is_finish;
    logic                        is_read;
    logic                        bin_ok;
    logic                        pair;
    logic [lob_pkg::CNT_W-1:0]   na;
    logic [lob_pkg::CNT_W-1:0]   nb;
    logic [lob_pkg::SUM_W-1:0]   sum;
    logic [lob_pkg::BIN_W-1:0]   bin_idx;
    lob_pkg::hist_req_t          req;

    logic                        s1_valid_reg;
    logic [lob_pkg::KIND_W-1:0]  s1_kind_reg;
    logic [lob_pkg::ROW_W-1:0]   s1_row_reg;
    logic                        s1_bnd_reg;
    logic                        s1_pair_reg;
    logic [lob_pkg::CNT_W-1:0]   s1_ask_reg;
    logic [lob_pkg::CNT_W-1:0]   s1_bid_reg;
    logic                        s1_rdok_reg;
    logic [lob_pkg::COUNT_W-1:0] hist_count;
    logic [lob_pkg::COUNT_W-1:0] s1_count;

    logic                        m_tvalid_reg;
    logic [lob_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [lob_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic [lob_pkg::KIND_W-1:0]  m_tuser_reg;

    assign cfg_ready = 1'b1;
    assign en = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept = s_tvalid && s_tready;

    assign is_row = (s_tuser == lob_pkg::OP_ROW);
    assign is_finish = (s_tuser == lob_pkg::OP_FINISH);
    assign is_read = (s_tuser == lob_pkg::OP_READ);
    assign bin_idx = s_tdata[lob_pkg::BIN_IDX_OFS +: lob_pkg::BIN_W];
    assign bin_ok = bin_idx < lob_pkg::BIN_W'(lob_pkg::HIST_BINS);
    assign pair = is_row && have_prev_reg;

    // unpack levels
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            if (i < lob_pkg::HALF_LEVELS) begin
                cur_ask[i] = s_tdata[lob_pkg::ASK_LO_OFS + i * lob_pkg::LEVEL_W +:
                                     lob_pkg::LEVEL_W];
                cur_bid[i] = s_tdata[lob_pkg::BID_LO_OFS + i * lob_pkg::LEVEL_W +:
                                     lob_pkg::LEVEL_W];
            end else begin
                cur_ask[i] = s_tdata[lob_pkg::ASK_HI_OFS +
                                     (i - lob_pkg::HALF_LEVELS) * lob_pkg::LEVEL_W +:
                                     lob_pkg::LEVEL_W];
                cur_bid[i] = s_tdata[lob_pkg::BID_HI_OFS +
                                     (i - lob_pkg::HALF_LEVELS) * lob_pkg::LEVEL_W +:
                                     lob_pkg::LEVEL_W];
            end
        end
    end

    lob_match #(.LEVELS(LEVELS)) u_ask_match (
        .prev_lvl (prev_ask_reg),
        .cur_lvl  (cur_ask),
        .count    (na)
    );

    lob_match #(.LEVELS(LEVELS)) u_bid_match (
        .prev_lvl (prev_bid_reg),
        .cur_lvl  (cur_bid),
        .count    (nb)
    );

    assign sum = lob_pkg::SUM_W'(na) + lob_pkg::SUM_W'(nb);

    always_comb begin
        req.bump = accept && pair;
        req.rd = accept && (pair || (is_read && bin_ok));
        if (is_row) begin
            req.addr = lob_pkg::BIN_W'(na) * lob_pkg::BIN_W'(lob_pkg::HIST_SIDE) +
                       lob_pkg::BIN_W'(nb);
        end else begin
            req.addr = bin_idx;
        end
    end

    lob_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .req     (req),
        .count   (hist_count)
    );

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= lob_pkg::THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            row_cnt_reg <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                prev_ask_reg[i] <= '0;
                prev_bid_reg[i] <= '0;
            end
        end else if (accept && is_row) begin
            have_prev_reg <= 1'b1;
            row_cnt_reg <= row_cnt_reg + lob_pkg::ROW_W'(1);
            prev_ask_reg <= cur_ask;
            prev_bid_reg <= cur_bid;
        end else if (accept && is_finish) begin
            have_prev_reg <= 1'b0;
            row_cnt_reg <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                prev_ask_reg[i] <= '0;
                prev_bid_reg[i] <= '0;
            end
        end
    end

    // stage 1: wait for histogram read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept && (is_row || is_finish || is_read);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_kind_reg <= s_tuser;
            s1_row_reg <= is_read ? '0 : row_cnt_reg;
            s1_pair_reg <= pair;
            s1_bnd_reg <= pair && (sum <= lob_pkg::SUM_W'(thr_reg));
            s1_ask_reg <= pair ? na : '0;
            s1_bid_reg <= pair ? nb : '0;
            s1_rdok_reg <= is_read && bin_ok;
        end
    end

    assign s1_count = s1_rdok_reg ? hist_count : '0;

    assign m_tdata_next = {{lob_pkg::M_PAD_W{1'b0}}, s1_count, s1_bid_reg, s1_ask_reg,
                           s1_pair_reg, s1_bnd_reg, s1_row_reg};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= s1_kind_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

`ifndef ASSERT_OFF
    a_unpaired_row_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_pair_reg |->
            s1_ask_reg == '0 && s1_bid_reg == '0 && !s1_bnd_reg)
        else $error("unpaired row carries overlap data");

    a_ignored_op_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_row && !is_finish && !is_read |=> !s1_valid_reg)
        else $error("ignored opcode produced a result");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_finish |=> row_cnt_reg == '0 && !have_prev_reg)
        else $error("finish did not clear stream state");

    a_read_no_row: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_kind_reg == lob_pkg::OP_READ |->
            s1_row_reg == '0 && !s1_pair_reg)
        else $error("read result carries row fields");
`endif

endmodule
